// ===== src/rwmf_pkg.sv =====
package rwmf_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W = 8;
    localparam int ROW_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

    typedef struct packed {
        logic accept;
        logic start;
        logic tap_read;
        logic tap_store;
        logic tap_step;
        logic sort_pass;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic emit_needed;
        logic tap_ok;
        logic tap_last;
        logic sort_done;
        logic out_free;
    } sts_t;

endpackage

// ===== src/rwmf_ctrl.sv =====
module rwmf_ctrl
    import rwmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TAP_ADDR = 3'd1;
    localparam logic [2:0] S_TAP_DATA = 3'd2;
    localparam logic [2:0] S_SORT = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.emit_needed)
                    begin
                        cmd.start = 1'b1;
                        state_next = S_TAP_ADDR;
                    end
                end
            end
            S_TAP_ADDR:
            begin
                if (sts.tap_ok)
                begin
                    cmd.tap_read = 1'b1;
                    state_next = S_TAP_DATA;
                end
                else
                begin
                    cmd.tap_step = 1'b1;
                    if (sts.tap_last)
                    begin
                        state_next = S_SORT;
                    end
                end
            end
            S_TAP_DATA:
            begin
                cmd.tap_store = 1'b1;
                cmd.tap_step = 1'b1;
                state_next = sts.tap_last ? S_SORT : S_TAP_ADDR;
            end
            S_SORT:
            begin
                if (sts.sort_done)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.sort_pass = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rwmf_datapath.sv =====
module rwmf_datapath
    import rwmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_RADIUS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  mode,
    input  logic [PIX_W-1:0]      red_in,
    input  logic [PIX_W-1:0]      green_in,
    input  logic [PIX_W-1:0]      blue_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      red_out,
    output logic [PIX_W-1:0]      green_out,
    output logic [PIX_W-1:0]      blue_out,
    output logic                  frame_end,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int RS = 2 * MAX_RADIUS + 2;
    localparam int SW = $clog2(RS);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(RS * MAX_WIDTH);
    localparam int DW = $clog2(2 * MAX_RADIUS + 1);
    localparam int WIN = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int NW = $clog2(WIN + 1);
    localparam int IW = $clog2(WIN);
    localparam int PW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);

    logic [10:0]      width_cfg_reg;
    logic [ROW_W-1:0] height_cfg_reg;
    logic [1:0]       radius_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= 11'd1024;
            height_cfg_reg <= 13'd768;
            radius_cfg_reg <= 2'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: width_cfg_reg <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                CFG_WINDOW_RADIUS: radius_cfg_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [1:0]       rad;

    always_comb
    begin
        if (width_cfg_reg == 11'd0)
        begin
            w_eff = WW'(1);
        end
        else if ({2'b00, width_cfg_reg} > 13'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_cfg_reg);
        end
        h_eff = (height_cfg_reg == '0) ? ROW_W'(1) : height_cfg_reg;
        rad = (radius_cfg_reg > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : radius_cfg_reg;
    end

    logic [CW-1:0]    in_col_reg, out_col_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic [SW-1:0]    in_slot_reg, out_slot_reg;
    logic [PW-1:0]    pending_reg;
    logic [PW-1:0]    pending_inc;
    logic [PW-1:0]    threshold;
    logic             in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
    logic             pixel_wr;

    assign pixel_wr = cmd.accept && !mode;
    assign pending_inc = pending_reg + PW'(1);
    assign threshold = PW'(rad) * PW'(w_eff) + PW'(rad);
    assign in_col_wrap = (WW'(in_col_reg) + WW'(1)) >= w_eff;
    assign in_row_wrap = ({1'b0, in_row_reg} + 14'd1) >= {1'b0, h_eff};
    assign out_col_wrap = (WW'(out_col_reg) + WW'(1)) >= w_eff;
    assign out_row_wrap = ({1'b0, out_row_reg} + 14'd1) >= {1'b0, h_eff};
    assign sts.emit_needed = mode ? (pending_reg != '0) : (pending_inc > threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            in_slot_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_slot_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (pixel_wr)
            begin
                if (in_col_wrap)
                begin
                    in_col_reg <= '0;
                    in_slot_reg <= (in_slot_reg == SW'(RS - 1)) ? '0 : in_slot_reg + SW'(1);
                    in_row_reg <= in_row_wrap ? '0 : in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (cmd.emit)
            begin
                if (out_col_wrap)
                begin
                    out_col_reg <= '0;
                    out_slot_reg <= (out_slot_reg == SW'(RS - 1)) ? '0 : out_slot_reg + SW'(1);
                    out_row_reg <= out_row_wrap ? '0 : out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
            if (pixel_wr && !cmd.emit)
            begin
                pending_reg <= pending_inc;
            end
            else if (!pixel_wr && cmd.emit)
            begin
                pending_reg <= pending_reg - PW'(1);
            end
        end
    end

    logic [DW-1:0]    dr_reg, dc_reg;
    logic [DW-1:0]    tap_span;
    logic [CW:0]      cc_ext;
    logic [CW:0]      cc_off;
    logic [ROW_W:0]   rr_ext;
    logic [ROW_W:0]   rr_off;
    logic [SW+1:0]    slot_raw, slot_a;
    logic [SW-1:0]    tap_slot;
    logic [AW-1:0]    rd_addr, wr_addr;

    assign tap_span = DW'({rad, 1'b0});
    assign cc_ext = (CW+1)'(out_col_reg) + (CW+1)'(dc_reg);
    assign cc_off = cc_ext - (CW+1)'(rad);
    assign rr_ext = {1'b0, out_row_reg} + (ROW_W+1)'(dr_reg);
    assign rr_off = rr_ext - (ROW_W+1)'(rad);
    assign slot_raw = (SW+2)'(out_slot_reg) + (SW+2)'(dr_reg) + (SW+2)'(RS) - (SW+2)'(rad);
    assign slot_a = (slot_raw >= (SW+2)'(RS)) ? slot_raw - (SW+2)'(RS) : slot_raw;
    assign tap_slot = (slot_a >= (SW+2)'(RS)) ? SW'(slot_a - (SW+2)'(RS)) : SW'(slot_a);
    assign sts.tap_ok = (cc_ext >= (CW+1)'(rad)) && (cc_off < (CW+1)'(w_eff))
                        && (rr_ext >= (ROW_W+1)'(rad)) && (rr_off < {1'b0, h_eff});
    assign sts.tap_last = (dr_reg == tap_span) && (dc_reg == tap_span);
    assign rd_addr = AW'(tap_slot) * AW'(MAX_WIDTH) + AW'(cc_off[CW-1:0]);
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);

    logic [3*PIX_W-1:0] line_mem [RS*MAX_WIDTH];
    logic [3*PIX_W-1:0] mem_q;

    always_ff @(posedge clk)
    begin
        if (pixel_wr)
        begin
            line_mem[wr_addr] <= {red_in, green_in, blue_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tap_read)
        begin
            mem_q <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dr_reg <= '0;
            dc_reg <= '0;
        end
        else if (cmd.start)
        begin
            dr_reg <= '0;
            dc_reg <= '0;
        end
        else if (cmd.tap_step)
        begin
            if (dc_reg == tap_span)
            begin
                dc_reg <= '0;
                dr_reg <= dr_reg + DW'(1);
            end
            else
            begin
                dc_reg <= dc_reg + DW'(1);
            end
        end
    end

    logic [PIX_W-1:0] win_r_reg [WIN];
    logic [PIX_W-1:0] win_g_reg [WIN];
    logic [PIX_W-1:0] win_b_reg [WIN];
    logic [PIX_W-1:0] sort_r [WIN];
    logic [PIX_W-1:0] sort_g [WIN];
    logic [PIX_W-1:0] sort_b [WIN];
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    pass_reg;

    assign sts.sort_done = pass_reg >= count_reg;

    always_comb
    begin
        for (int k = 0; k < WIN; k++)
        begin
            sort_r[k] = win_r_reg[k];
            sort_g[k] = win_g_reg[k];
            sort_b[k] = win_b_reg[k];
        end
        for (int j = 0; j < WIN - 1; j++)
        begin
            if ((j % 2 == int'(pass_reg[0])) && (NW'(j + 1) < count_reg))
            begin
                if (win_r_reg[j] > win_r_reg[j+1])
                begin
                    sort_r[j] = win_r_reg[j+1];
                    sort_r[j+1] = win_r_reg[j];
                end
                if (win_g_reg[j] > win_g_reg[j+1])
                begin
                    sort_g[j] = win_g_reg[j+1];
                    sort_g[j+1] = win_g_reg[j];
                end
                if (win_b_reg[j] > win_b_reg[j+1])
                begin
                    sort_b[j] = win_b_reg[j+1];
                    sort_b[j+1] = win_b_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pass_reg <= '0;
        end
        else if (cmd.start)
        begin
            count_reg <= '0;
            pass_reg <= '0;
        end
        else
        begin
            if (cmd.tap_store)
            begin
                count_reg <= count_reg + NW'(1);
            end
            if (cmd.sort_pass)
            begin
                pass_reg <= pass_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tap_store)
        begin
            win_r_reg[count_reg[IW-1:0]] <= mem_q[23:16];
            win_g_reg[count_reg[IW-1:0]] <= mem_q[15:8];
            win_b_reg[count_reg[IW-1:0]] <= mem_q[7:0];
        end
        else if (cmd.sort_pass)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                win_r_reg[k] <= sort_r[k];
                win_g_reg[k] <= sort_g[k];
                win_b_reg[k] <= sort_b[k];
            end
        end
    end

    logic [IW-1:0]    mid_hi, mid_lo;
    logic [PIX_W:0]   sum_r, sum_g, sum_b;
    logic [PIX_W-1:0] med_r, med_g, med_b;

    assign mid_hi = IW'(count_reg >> 1);
    assign mid_lo = mid_hi - IW'(1);
    assign sum_r = {1'b0, win_r_reg[mid_hi]} + {1'b0, win_r_reg[mid_lo]};
    assign sum_g = {1'b0, win_g_reg[mid_hi]} + {1'b0, win_g_reg[mid_lo]};
    assign sum_b = {1'b0, win_b_reg[mid_hi]} + {1'b0, win_b_reg[mid_lo]};

    always_comb
    begin
        if (count_reg == '0)
        begin
            med_r = '0;
            med_g = '0;
            med_b = '0;
        end
        else if (count_reg[0])
        begin
            med_r = win_r_reg[mid_hi];
            med_g = win_g_reg[mid_hi];
            med_b = win_b_reg[mid_hi];
        end
        else
        begin
            med_r = sum_r[PIX_W:1];
            med_g = sum_g[PIX_W:1];
            med_b = sum_b[PIX_W:1];
        end
    end

    logic out_valid_reg;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            red_out <= med_r;
            green_out <= med_g;
            blue_out <= med_b;
            frame_end <= out_col_wrap && out_row_wrap;
        end
    end

endmodule

// ===== src/rgb_window_median_filter.sv =====
// Order: a result leaves R rows and R pixels after its pixel; computing it reads and
// stores each window tap inside the frame, steps past each clipped tap, then runs
// one sort pass per tap gathered before the result is emitted.
// Throughput: one item at a time, set by the single read port of the line store
// and the shared odd-even sorter; an item causing no result leaves the block idle.
// Reset: async active-low; positions, counts, config and flags reset, pixel data does not.
module rgb_window_median_filter
    import rwmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_RADIUS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [PIX_W-1:0]      red_in,
    input  logic [PIX_W-1:0]      green_in,
    input  logic [PIX_W-1:0]      blue_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      red_out,
    output logic [PIX_W-1:0]      green_out,
    output logic [PIX_W-1:0]      blue_out,
    output logic                  frame_end
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    rwmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rwmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("Result register not loaded after emit.");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !sts.emit_needed) |=> in_ready)
        else $error("Request without result did not return to idle.");

    a_store_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tap_store |-> $past(cmd.tap_read))
        else $error("Window tap stored without a preceding read.");

endmodule

// ===== test/tb_rgb_window_median_filter.sv =====
`timescale 1ns / 1ps

module tb_rgb_window_median_filter;
    import rwmf_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_R = 2;
    localparam int SLOTS = 2 * MAX_R + 2;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 120;

    typedef struct packed {
        logic       flush;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } median_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [PIX_W-1:0]      red_in;
    logic [PIX_W-1:0]      green_in;
    logic [PIX_W-1:0]      blue_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      red_out;
    logic [PIX_W-1:0]      green_out;
    logic [PIX_W-1:0]      blue_out;
    logic                  frame_end;

    rgb_window_median_filter u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .frame_end(frame_end)
    );

    pixel_req_t pending_px[$];
    median_t    medians_due[$];
    int         mismatches;
    int         cycles;
    bit         in_took;
    bit         calm;

    logic [23:0] rows_mem[SLOTS * MAX_W];
    int          m_width, m_height, m_radius;
    int          wr_col, wr_row, wr_slot, rd_col, rd_row, rd_slot, backlog;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int eff_w(int v);
        return (v == 0) ? 1 : ((v > MAX_W) ? MAX_W : v);
    endfunction

    function automatic int eff_h(int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int eff_r(int v);
        return (v > MAX_R) ? MAX_R : v;
    endfunction

    function automatic logic [7:0] median8(int vals[25], int n);
        int t;
        int j;
        if (n <= 0)
        begin
            return 8'd0;
        end
        for (int i = 1; i < n; i++)
        begin
            t = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > t)
            begin
                vals[j] = vals[j - 1];
                j--;
            end
            vals[j] = t;
        end
        if (n % 2 == 1)
        begin
            return vals[n / 2];
        end
        return (vals[n / 2] + vals[n / 2 - 1]) / 2;
    endfunction

    task automatic step_pos(inout int col, inout int row, inout int slot,
                            input int w, input int h, output bit last);
        last = 1'b0;
        if (col + 1 >= w)
        begin
            col = 0;
            slot = (slot + 1) % SLOTS;
            if (row + 1 >= h)
            begin
                row = 0;
                last = 1'b1;
            end
            else
            begin
                row++;
            end
        end
        else
        begin
            col++;
        end
    endtask

    task automatic predict(input pixel_req_t req);
        int      w;
        int      h;
        int      rad;
        int      n;
        int      rr;
        int      cc;
        int      slot;
        int      rv[25];
        int      gv[25];
        int      bv[25];
        bit      last;
        median_t m;
        w = eff_w(m_width);
        h = eff_h(m_height);
        rad = eff_r(m_radius);
        n = 0;
        if (!req.flush)
        begin
            rows_mem[wr_slot * MAX_W + ((wr_col < MAX_W) ? wr_col : MAX_W - 1)] =
                {req.r, req.g, req.b};
            step_pos(wr_col, wr_row, wr_slot, w, h, last);
            backlog++;
            if (backlog <= rad * w + rad)
            begin
                return;
            end
        end
        else if (backlog == 0)
        begin
            return;
        end
        for (int dr = -rad; dr <= rad; dr++)
        begin
            rr = rd_row + dr;
            if (rr < 0 || rr >= h)
            begin
                continue;
            end
            slot = (rd_slot + SLOTS + dr) % SLOTS;
            for (int dc = -rad; dc <= rad; dc++)
            begin
                cc = rd_col + dc;
                if (cc < 0 || cc >= w)
                begin
                    continue;
                end
                rv[n] = rows_mem[slot * MAX_W + cc][23:16];
                gv[n] = rows_mem[slot * MAX_W + cc][15:8];
                bv[n] = rows_mem[slot * MAX_W + cc][7:0];
                n++;
            end
        end
        m.r = median8(rv, n);
        m.g = median8(gv, n);
        m.b = median8(bv, n);
        step_pos(rd_col, rd_row, rd_slot, w, h, last);
        m.last = last;
        backlog--;
        medians_due.push_back(m);
    endtask

    // Checker and predictor share one edge; the result is checked before a new
    // request is predicted, since a result can never come from a same-edge request.
    always @(posedge clk)
    begin
        median_t exp_m;
        median_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rgb_window_median_filter: mismatch");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = '{red_out, green_out, blue_out, frame_end};
            if (medians_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result r=%0d g=%0d b=%0d end=%0d",
                             got.r, got.g, got.b, got.last);
                end
            end
            else
            begin
                exp_m = medians_due.pop_front();
                if (got !== exp_m)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result expected r=%0d g=%0d b=%0d end=%0d, got %0d %0d %0d %0d",
                                 exp_m.r, exp_m.g, exp_m.b, exp_m.last,
                                 got.r, got.g, got.b, got.last);
                    end
                end
            end
        end
        in_took = rst_n && in_valid && in_ready;
        if (in_took)
        begin
            predict('{mode, red_in, green_in, blue_in});
        end
    end

    always @(negedge clk)
    begin
        pixel_req_t req;
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (pending_px.size() > 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    req = pending_px.pop_front();
                    in_valid <= 1'b1;
                    mode <= req.flush;
                    red_in <= req.r;
                    green_in <= req.g;
                    blue_in <= req.b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_IMAGE_WIDTH: m_width = value & 16'h7FF;
            CFG_IMAGE_HEIGHT: m_height = value & 16'h1FFF;
            CFG_WINDOW_RADIUS: m_radius = value & 3;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] sample_val();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Queues n pixels, then enough flushes to drain every pending result, plus
    // one flush that finds nothing to drain.
    task automatic run_frame(input int w, input int h, input int rad, input int n,
                             input bit extreme);
        pixel_req_t req;
        int         ew;
        int         left;
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_WINDOW_RADIUS, rad);
        ew = eff_w(w & 16'h7FF);
        left = eff_r(rad) * ew + eff_r(rad);
        if (n < left)
        begin
            left = n;
        end
        for (int i = 0; i < n; i++)
        begin
            req.flush = 1'b0;
            if (extreme)
            begin
                req.r = (i % 2 == 1) ? 8'd255 : 8'd0;
                req.g = (i % 3 == 0) ? 8'd255 : 8'd0;
                req.b = 8'($urandom);
            end
            else
            begin
                req.r = sample_val();
                req.g = sample_val();
                req.b = sample_val();
            end
            pending_px.push_back(req);
        end
        for (int i = 0; i <= left; i++)
        begin
            req = 25'($urandom);
            req.flush = 1'b1;
            pending_px.push_back(req);
        end
        while (pending_px.size() > 0 || in_valid || medians_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int pixels;
        int w;
        int h;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        out_ready = 1'b0;
        in_took = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        cycles = 0;
        m_width = 1024;
        m_height = 768;
        m_radius = 1;
        wr_col = 0;
        wr_row = 0;
        wr_slot = 0;
        rd_col = 0;
        rd_row = 0;
        rd_slot = 0;
        backlog = 0;
        for (int i = 0; i < SLOTS * MAX_W; i++)
        begin
            rows_mem[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_frame(0, 0, 0, 1, 1'b1);
        run_frame(1, 5, 2, 5, 1'b1);
        run_frame(3, 2, 3, 6, 1'b1);
        run_frame(4, 3, 1, 12, 1'b1);

        pixels = 0;
        while (pixels < 300)
        begin
            calm = (pixels > 80 && pixels < 200);
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 10);
            run_frame(w, h, $urandom_range(0, 3), w * h, 1'b0);
            pixels += w * h;
        end
        calm = 1'b0;
        // With a zero radius each pixel reads only itself, so a partial row is safe.
        run_frame(2047, 1, 0, 100, 1'b0);
        // The frame is left open here, so this must stay the last one.
        run_frame(1, 8191, 2, 40, 1'b0);

        if (mismatches == 0)
        begin
            $display("rgb_window_median_filter: match");
        end
        else
        begin
            $display("rgb_window_median_filter: mismatch");
        end
        $finish;
    end

endmodule
